/* rtl/dnsrp_pkg.sv */
// Constants and types shared by the DNS reply parser and its checker.
`default_nettype none

package dnsrp_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int OFF_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [3:0] HDR_LAST_BYTE = 4'd11;
    localparam int         FULL_HEADER   = 12;

    localparam logic [15:0] FLAG_QR = 16'h8000;
    localparam logic [15:0] FLAG_TC = 16'h0200;

    localparam logic [7:0]  PTR_MASK   = 8'hc0;
    localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;
    localparam logic [15:0] A_RDLEN   = 16'd4;

    localparam logic [3:0] NAME_FRESH   = 4'd0;
    localparam logic [3:0] NAME_INSIDE  = 4'd1;
    localparam logic [3:0] NAME_POINTER = 4'd2;

    localparam logic [3:0] QFIELD_LEN = 4'd4;
    localparam logic [3:0] AFIELD_LEN = 4'd10;
    localparam logic [3:0] TTL_FIRST  = 4'd4;
    localparam logic [3:0] RDLEN_FIRST = 4'd8;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd1;
    localparam logic [2:0] ST_TRUNCATED    = 3'd2;
    localparam logic [2:0] ST_NO_ANSWERS   = 3'd3;
    localparam logic [2:0] ST_FORMAT_ERROR = 3'd4;
    localparam logic [2:0] ST_NO_A_RECORD  = 3'd5;

    typedef enum logic [6:0] {
        PH_HDR    = 7'b0000001,
        PH_QNAME  = 7'b0000010,
        PH_QFIELD = 7'b0000100,
        PH_ANAME  = 7'b0001000,
        PH_AFIELD = 7'b0010000,
        PH_RDATA  = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

endpackage

`default_nettype wire

/* rtl/dns_response_parser.sv */
// DNS reply parser: finds the first IN/A answer of a reply fed one byte per transaction.
//
// Input channel: i_in_valid / o_in_stall carry one packet byte per transaction,
// with i_last_byte set on the packet's final byte. Output channel:
// o_out_valid / i_out_stall carry one result per packet (status, reply id,
// address, TTL), produced for the transaction that carried the last byte.
// Throughput is one byte per clock while o_in_stall is low. A byte accepted
// sits in the input register and is parsed from there; if it was the last
// byte, its result is then held in the output register until it is taken.
// The parser state is updated in that single step, so bytes flow back to back.
// Bytes beyond MAX_PACKET_BYTES are counted out and ignored; the packet is
// judged on the bytes kept. After each result all parsing state clears.
// While a result waits under i_out_stall, non-final bytes keep flowing; only
// a final byte waiting behind an untaken result raises o_in_stall.
// Synchronous active-low reset clears both registers' valid flags and all
// parsing state; the block is ready for a new packet in the next cycle.
`default_nettype none

module dns_response_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_reply_id,
    output logic [31:0]      o_ip_address,
    output logic [31:0]      o_ttl_seconds
);

    localparam int OW = dnsrp_pkg::OFF_W;

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [OW-1:0]    r_offset,  n_offset;
    dnsrp_pkg::t_phase r_phase,  n_phase;
    logic [7:0]       r_nleft,   n_nleft;
    logic [3:0]       r_field,   n_field;
    logic [15:0]      r_qleft,   n_qleft;
    logic [15:0]      r_aleft,   n_aleft;
    logic [15:0]      r_flags,   n_flags;
    logic [15:0]      r_id,      n_id;
    logic [31:0]      r_rtc,     n_rtc;
    logic [31:0]      r_ttl,     n_ttl;
    logic [15:0]      r_rdlen,   n_rdlen;
    logic [31:0]      r_addr,    n_addr;
    logic [2:0]       r_outcome, n_outcome;

    logic             r_out_vld;
    logic [2:0]       r_status,  n_status;
    logic [15:0]      r_rid,     n_rid;
    logic [31:0]      r_ip,      n_ip;
    logic [31:0]      r_rttl,    n_rttl;

    logic             adv;
    logic             in_take;

    logic             nm_done;
    logic [7:0]       nm_left;
    logic [3:0]       nm_field;
    logic [15:0]      aleft_dec;
    logic [15:0]      qleft_dec;

    assign adv        = r_in_vld && (!r_in_last || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    assign aleft_dec = r_aleft - 16'd1;
    assign qleft_dec = r_qleft - 16'd1;

    // one byte of a name: labels, zero terminator or two-byte pointer
    always_comb begin
        nm_done  = 1'b0;
        nm_left  = r_nleft;
        nm_field = r_field;
        if (r_field == dnsrp_pkg::NAME_POINTER) begin
            nm_field = dnsrp_pkg::NAME_FRESH;
            nm_done  = 1'b1;
        end else if (r_nleft != 8'd0) begin
            nm_left = r_nleft - 8'd1;
        end else if (r_in_byte == 8'd0) begin
            nm_field = dnsrp_pkg::NAME_FRESH;
            nm_done  = 1'b1;
        end else if ((r_in_byte & dnsrp_pkg::PTR_MASK) == dnsrp_pkg::PTR_MASK) begin
            nm_field = dnsrp_pkg::NAME_POINTER;
        end else begin
            nm_left  = r_in_byte;
            nm_field = dnsrp_pkg::NAME_INSIDE;
        end
    end

    always_comb begin
        n_offset  = r_offset;
        n_phase   = r_phase;
        n_nleft   = r_nleft;
        n_field   = r_field;
        n_qleft   = r_qleft;
        n_aleft   = r_aleft;
        n_flags   = r_flags;
        n_id      = r_id;
        n_rtc     = r_rtc;
        n_ttl     = r_ttl;
        n_rdlen   = r_rdlen;
        n_addr    = r_addr;
        n_outcome = r_outcome;
        n_status  = dnsrp_pkg::ST_FORMAT_ERROR;
        n_rid     = 16'd0;
        n_ip      = 32'd0;
        n_rttl    = 32'd0;

        if (r_offset < OW'(dnsrp_pkg::MAX_PACKET_BYTES)) begin
            n_offset = r_offset + OW'(1);
            case (r_phase)
                dnsrp_pkg::PH_HDR: begin
                    case (r_offset[3:0])
                        4'd0, 4'd1: n_id    = {r_id[7:0], r_in_byte};
                        4'd2, 4'd3: n_flags = {r_flags[7:0], r_in_byte};
                        4'd4, 4'd5: n_qleft = {r_qleft[7:0], r_in_byte};
                        4'd6, 4'd7: n_aleft = {r_aleft[7:0], r_in_byte};
                        default: ;
                    endcase
                    if (r_offset[3:0] == dnsrp_pkg::HDR_LAST_BYTE) begin
                        if ((r_flags & dnsrp_pkg::FLAG_QR) == 16'd0) begin
                            n_outcome = dnsrp_pkg::ST_NOT_RESPONSE;
                            n_phase   = dnsrp_pkg::PH_DONE;
                        end else if ((r_flags & dnsrp_pkg::FLAG_TC) != 16'd0) begin
                            n_outcome = dnsrp_pkg::ST_TRUNCATED;
                            n_phase   = dnsrp_pkg::PH_DONE;
                        end else if (r_aleft == 16'd0) begin
                            n_outcome = dnsrp_pkg::ST_NO_ANSWERS;
                            n_phase   = dnsrp_pkg::PH_DONE;
                        end else begin
                            n_phase = (r_qleft != 16'd0) ? dnsrp_pkg::PH_QNAME
                                                         : dnsrp_pkg::PH_ANAME;
                            n_field = dnsrp_pkg::NAME_FRESH;
                        end
                    end
                end
                dnsrp_pkg::PH_QNAME: begin
                    n_nleft = nm_left;
                    n_field = nm_field;
                    if (nm_done) begin
                        n_phase = dnsrp_pkg::PH_QFIELD;
                        n_field = 4'd0;
                    end
                end
                dnsrp_pkg::PH_QFIELD: begin
                    n_field = r_field + 4'd1;
                    if (n_field >= dnsrp_pkg::QFIELD_LEN) begin
                        n_field = dnsrp_pkg::NAME_FRESH;
                        n_qleft = qleft_dec;
                        n_phase = (qleft_dec != 16'd0) ? dnsrp_pkg::PH_QNAME
                                                       : dnsrp_pkg::PH_ANAME;
                    end
                end
                dnsrp_pkg::PH_ANAME: begin
                    n_nleft = nm_left;
                    n_field = nm_field;
                    if (nm_done) begin
                        n_phase = dnsrp_pkg::PH_AFIELD;
                        n_field = 4'd0;
                    end
                end
                dnsrp_pkg::PH_AFIELD: begin
                    if (r_field < dnsrp_pkg::TTL_FIRST) begin
                        n_rtc = {r_rtc[23:0], r_in_byte};
                    end else if (r_field < dnsrp_pkg::RDLEN_FIRST) begin
                        n_ttl = {r_ttl[23:0], r_in_byte};
                    end else begin
                        n_rdlen = {r_rdlen[7:0], r_in_byte};
                    end
                    n_field = r_field + 4'd1;
                    if (n_field >= dnsrp_pkg::AFIELD_LEN) begin
                        n_field = 4'd0;
                        n_addr  = 32'd0;
                        if (n_rdlen != dnsrp_pkg::A_RDLEN) begin
                            n_rtc = 32'd0;
                        end
                        if (n_rdlen == 16'd0) begin
                            n_aleft = aleft_dec;
                            if (aleft_dec == 16'd0) begin
                                n_outcome = dnsrp_pkg::ST_NO_A_RECORD;
                                n_phase   = dnsrp_pkg::PH_DONE;
                            end else begin
                                n_phase = dnsrp_pkg::PH_ANAME;
                                n_field = dnsrp_pkg::NAME_FRESH;
                            end
                        end else begin
                            n_phase = dnsrp_pkg::PH_RDATA;
                        end
                    end
                end
                dnsrp_pkg::PH_RDATA: begin
                    n_addr  = {r_addr[23:0], r_in_byte};
                    n_rdlen = r_rdlen - 16'd1;
                    if (n_rdlen == 16'd0) begin
                        if (r_rtc == dnsrp_pkg::TYPE_CLASS_A_IN) begin
                            n_outcome = dnsrp_pkg::ST_OK;
                            n_phase   = dnsrp_pkg::PH_DONE;
                        end else begin
                            n_aleft = aleft_dec;
                            if (aleft_dec == 16'd0) begin
                                n_outcome = dnsrp_pkg::ST_NO_A_RECORD;
                                n_phase   = dnsrp_pkg::PH_DONE;
                            end else begin
                                n_phase = dnsrp_pkg::PH_ANAME;
                                n_field = dnsrp_pkg::NAME_FRESH;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (n_phase == dnsrp_pkg::PH_DONE) begin
            n_status = n_outcome;
        end else if (n_phase == dnsrp_pkg::PH_HDR) begin
            n_status = dnsrp_pkg::ST_NOT_RESPONSE;
        end else if (n_phase == dnsrp_pkg::PH_ANAME && n_field == dnsrp_pkg::NAME_FRESH
                     && n_nleft == 8'd0) begin
            n_status = dnsrp_pkg::ST_NO_A_RECORD;
        end
        if (n_offset >= OW'(dnsrp_pkg::FULL_HEADER)) begin
            n_rid = n_id;
        end
        if (n_status == dnsrp_pkg::ST_OK) begin
            n_ip   = n_addr;
            n_rttl = n_ttl;
        end

        // end of packet: back to the reset state
        if (r_in_last) begin
            n_offset  = '0;
            n_phase   = dnsrp_pkg::PH_HDR;
            n_nleft   = 8'd0;
            n_field   = 4'd0;
            n_qleft   = 16'd0;
            n_aleft   = 16'd0;
            n_flags   = 16'd0;
            n_id      = 16'd0;
            n_rtc     = 32'd0;
            n_ttl     = 32'd0;
            n_rdlen   = 16'd0;
            n_addr    = 32'd0;
            n_outcome = dnsrp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_phase   <= dnsrp_pkg::PH_HDR;
            r_nleft   <= 8'd0;
            r_field   <= 4'd0;
            r_qleft   <= 16'd0;
            r_aleft   <= 16'd0;
            r_flags   <= 16'd0;
            r_id      <= 16'd0;
            r_rtc     <= 32'd0;
            r_ttl     <= 32'd0;
            r_rdlen   <= 16'd0;
            r_addr    <= 32'd0;
            r_outcome <= dnsrp_pkg::ST_OK;
        end else if (adv) begin
            r_offset  <= n_offset;
            r_phase   <= n_phase;
            r_nleft   <= n_nleft;
            r_field   <= n_field;
            r_qleft   <= n_qleft;
            r_aleft   <= n_aleft;
            r_flags   <= n_flags;
            r_id      <= n_id;
            r_rtc     <= n_rtc;
            r_ttl     <= n_ttl;
            r_rdlen   <= n_rdlen;
            r_addr    <= n_addr;
            r_outcome <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_ip     <= n_ip;
            r_rttl   <= n_rttl;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_reply_id    = r_rid;
    assign o_ip_address  = r_ip;
    assign o_ttl_seconds = r_rttl;

endmodule

`default_nettype wire

/* rtl/dnsrp_checker.sv */
// Port-level checks for the DNS reply parser, bound into the parser module.
`default_nettype none

module dnsrp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_reply_id,
    input wire logic [31:0] o_ip_address,
    input wire logic [31:0] o_ttl_seconds
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_reply_id) && $stable(o_ip_address) && $stable(o_ttl_seconds))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= dnsrp_pkg::ST_NO_A_RECORD)
        else $error("status code out of range");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != dnsrp_pkg::ST_OK
            |-> o_ip_address == 32'd0 && o_ttl_seconds == 32'd0)
        else $error("address or ttl set on a failed transaction");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind dns_response_parser dnsrp_checker u_dnsrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_reply_id    (o_reply_id),
    .o_ip_address  (o_ip_address),
    .o_ttl_seconds (o_ttl_seconds)
);

`default_nettype wire

/* verif/dnsrp_reply_checker.sv */
// Reply checker: predicts each DNS parse result from the accepted bytes and compares the outputs.
module dnsrp_reply_checker
    import dnsrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_status,
    input  wire logic [15:0] i_reply_id,
    input  wire logic [31:0] i_ip_address,
    input  wire logic [31:0] i_ttl_seconds,
    output int               o_mismatches,
    output int               o_results_owed
);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] reply_id;
        logic [31:0] ip;
        logic [31:0] ttl;
    } t_parse_result;

    t_parse_result results_owed[$];

    logic [OFF_W-1:0] bytes_kept;
    t_phase           phase;
    logic [7:0]       skip_left;
    logic [3:0]       step_idx;
    logic [15:0]      qd_left;
    logic [15:0]      an_left;
    logic [15:0]      hdr_flags;
    logic [15:0]      id_hold;
    logic [31:0]      rr_type_class;
    logic [31:0]      rr_ttl;
    logic [15:0]      rr_len;
    logic [31:0]      rr_addr;
    logic [2:0]       verdict;

    task automatic restart_parse();
        bytes_kept    = '0;
        phase         = PH_HDR;
        skip_left     = '0;
        step_idx      = NAME_FRESH;
        qd_left       = '0;
        an_left       = '0;
        hdr_flags     = '0;
        id_hold       = '0;
        rr_type_class = '0;
        rr_ttl        = '0;
        rr_len        = '0;
        rr_addr       = '0;
        verdict       = ST_OK;
    endtask

    task automatic settle(input logic [2:0] code);
        verdict = code;
        phase   = PH_DONE;
    endtask

    // one byte of a name: labels, zero terminator or two-byte pointer
    function automatic bit name_ends(input logic [7:0] b);
        if (step_idx == NAME_POINTER) begin
            step_idx = NAME_FRESH;
            return 1'b1;
        end
        if (skip_left != 0) begin
            skip_left--;
            return 1'b0;
        end
        if (b == 8'd0) begin
            step_idx = NAME_FRESH;
            return 1'b1;
        end
        if ((b & PTR_MASK) == PTR_MASK) begin
            step_idx = NAME_POINTER;
            return 1'b0;
        end
        skip_left = b;
        step_idx  = NAME_INSIDE;
        return 1'b0;
    endfunction

    task automatic answer_end();
        if (rr_type_class == TYPE_CLASS_A_IN) begin
            settle(ST_OK);
        end else begin
            an_left--;
            if (an_left == 0) begin
                settle(ST_NO_A_RECORD);
            end else begin
                phase    = PH_ANAME;
                step_idx = NAME_FRESH;
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            PH_HDR: begin
                case (bytes_kept)
                    0, 1: id_hold = {id_hold[7:0], b};
                    2, 3: hdr_flags = {hdr_flags[7:0], b};
                    4, 5: qd_left = {qd_left[7:0], b};
                    6, 7: an_left = {an_left[7:0], b};
                    default: ;
                endcase
                if (bytes_kept == OFF_W'(HDR_LAST_BYTE)) begin
                    if ((hdr_flags & FLAG_QR) == 0) settle(ST_NOT_RESPONSE);
                    else if ((hdr_flags & FLAG_TC) != 0) settle(ST_TRUNCATED);
                    else if (an_left == 0) settle(ST_NO_ANSWERS);
                    else begin
                        phase    = (qd_left != 0) ? PH_QNAME : PH_ANAME;
                        step_idx = NAME_FRESH;
                    end
                end
            end
            PH_QNAME: begin
                if (name_ends(b)) begin
                    phase    = PH_QFIELD;
                    step_idx = '0;
                end
            end
            PH_QFIELD: begin
                step_idx++;
                if (step_idx >= QFIELD_LEN) begin
                    step_idx = NAME_FRESH;
                    qd_left--;
                    phase = (qd_left != 0) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_ANAME: begin
                if (name_ends(b)) begin
                    phase    = PH_AFIELD;
                    step_idx = '0;
                end
            end
            PH_AFIELD: begin
                if (step_idx < TTL_FIRST) rr_type_class = {rr_type_class[23:0], b};
                else if (step_idx < RDLEN_FIRST) rr_ttl = {rr_ttl[23:0], b};
                else rr_len = {rr_len[7:0], b};
                step_idx++;
                if (step_idx >= AFIELD_LEN) begin
                    step_idx = '0;
                    rr_addr  = '0;
                    if (rr_len != A_RDLEN) rr_type_class = '0;
                    if (rr_len == 0) answer_end();
                    else phase = PH_RDATA;
                end
            end
            PH_RDATA: begin
                rr_addr = {rr_addr[23:0], b};
                rr_len--;
                if (rr_len == 0) answer_end();
            end
            default: ;
        endcase
    endtask

    task automatic take_packet_byte(input logic [7:0] b, input logic fin);
        t_parse_result res;
        logic [2:0]    st;
        if (bytes_kept < MAX_PACKET_BYTES) begin
            if (phase != PH_DONE) parse_byte(b);
            bytes_kept++;
        end
        if (fin) begin
            if (phase == PH_DONE) st = verdict;
            else if (phase == PH_HDR) st = ST_NOT_RESPONSE;
            else if (phase == PH_ANAME && step_idx == NAME_FRESH && skip_left == 0)
                st = ST_NO_A_RECORD;
            else st = ST_FORMAT_ERROR;
            res.status   = st;
            res.reply_id = (bytes_kept >= FULL_HEADER) ? id_hold : 16'd0;
            res.ip       = (st == ST_OK) ? rr_addr : 32'd0;
            res.ttl      = (st == ST_OK) ? rr_ttl : 32'd0;
            results_owed.push_back(res);
            restart_parse();
        end
    endtask

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            o_mismatches++;
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        t_parse_result want;
        if (results_owed.size() == 0) begin
            o_mismatches++;
            $display("%0t: result with none expected: status %0d id %h ip %h ttl %h",
                     $time, i_status, i_reply_id, i_ip_address, i_ttl_seconds);
        end else begin
            want = results_owed.pop_front();
            flag_field("status", 32'(want.status), 32'(i_status));
            flag_field("reply_id", 32'(want.reply_id), 32'(i_reply_id));
            flag_field("ip_address", want.ip, i_ip_address);
            flag_field("ttl_seconds", want.ttl, i_ttl_seconds);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parse();
            results_owed.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) take_packet_byte(i_data_byte, i_last_byte);
        end
        o_results_owed = results_owed.size();
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for dns_response_parser: reset, DNS packet stimulus, idling and the verdict.
module tb_top;
    import dnsrp_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          ITEM_TARGET = 1650;
    localparam logic [31:0] CNAME_IN    = 32'h0005_0001;
    localparam logic [31:0] A_CHAOS     = 32'h0001_0003;
    localparam logic [31:0] AAAA_IN     = 32'h001c_0001;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] reply_id;
    logic [31:0] ip_address;
    logic [31:0] ttl_seconds;
    int          mismatches;
    int          results_owed;
    int          quiet_cycles;

    logic [7:0]  frame[$];
    bit          calm;
    int          bytes_sent;

    dns_response_parser DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_byte   (data_byte),
        .i_last_byte   (last_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_reply_id    (reply_id),
        .o_ip_address  (ip_address),
        .o_ttl_seconds (ttl_seconds)
    );

    dnsrp_reply_checker u_reply_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_reply_id     (reply_id),
        .i_ip_address   (ip_address),
        .i_ttl_seconds  (ttl_seconds),
        .o_mismatches   (mismatches),
        .o_results_owed (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic junk(input int n);
        repeat (n) frame.push_back(8'($urandom));
    endtask

    task automatic put16(input logic [15:0] v);
        frame.push_back(v[15:8]);
        frame.push_back(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic cut_to(input int n);
        while (frame.size() > n) void'(frame.pop_back());
    endtask

    task automatic hdr(input logic [15:0] id, input logic [15:0] fl,
                       input logic [15:0] qd, input logic [15:0] an);
        put16(id);
        put16(fl);
        put16(qd);
        put16(an);
        put32($urandom);
    endtask

    task automatic add_name();
        int         pick;
        logic [7:0] len;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            frame.push_back(8'd0);
        end else if (pick < 6) begin
            frame.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
            junk(1);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(64, 191))
                                                   : 8'($urandom_range(1, 5));
                frame.push_back(len);
                junk(len);
            end
            if ($urandom_range(0, 1) == 0) frame.push_back(8'd0);
            else begin
                frame.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
                junk(1);
            end
        end
    endtask

    task automatic question();
        add_name();
        put32($urandom);
    endtask

    task automatic answer(input logic [31:0] tc, input logic [31:0] ttl,
                          input logic [15:0] rdlen, input logic [31:0] ip);
        add_name();
        put32(tc);
        put32(ttl);
        put16(rdlen);
        if (rdlen == A_RDLEN) put32(ip);
        else junk(rdlen);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic fin);
        int gap;
        bit took;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic ship();
        calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < frame.size(); k++) put_byte(frame[k], k == frame.size() - 1);
        bytes_sent += frame.size();
        frame.delete();
    endtask

    task automatic build_random_frame();
        int          pick;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] fl;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            qd = 16'($urandom_range(0, 2));
            an = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
            fl = 16'($urandom) | FLAG_QR;
            if ($urandom_range(0, 9) != 0) fl = fl & ~FLAG_TC;
            hdr(16'($urandom), fl, qd, an);
            repeat (qd) question();
            repeat (an) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
                else if (pick < 7)
                    answer(TYPE_CLASS_A_IN, $urandom, 16'($urandom_range(0, 6)), $urandom);
                else if (pick < 8)
                    answer({16'd1, 16'($urandom_range(2, 255))}, $urandom, A_RDLEN, $urandom);
                else
                    answer({16'($urandom_range(2, 300)), 16'($urandom_range(1, 4))},
                           $urandom, 16'($urandom_range(0, 6)), $urandom);
            end
            if ($urandom_range(0, 3) == 0) cut_to($urandom_range(1, frame.size()));
            else if ($urandom_range(0, 5) == 0) junk($urandom_range(1, 4));
            if ($urandom_range(0, 79) == 0) junk(520 - frame.size());
        end else if (pick < 80) begin
            qd = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            an = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            hdr(16'($urandom), 16'($urandom), qd, an);
            junk($urandom_range(0, 30));
        end else if (pick < 92) begin
            junk($urandom_range(1, 40));
        end else begin
            junk($urandom_range(1, 11));
        end
    endtask

    // receiver side: random stall ahead of each result
    initial begin
        int hold;
        bit took;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do begin
                @(negedge clk);
                took = out_valid;
                @(posedge clk);
            end while (!took);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'd0;
        last_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short packets and header verdicts
        frame.push_back(8'hff);
        ship();
        junk(11);
        ship();
        hdr(16'h1234, 16'h0100, 16'd1, 16'd1);
        ship();
        hdr(16'hbeef, FLAG_QR | FLAG_TC, 16'd1, 16'd1);
        question();
        ship();
        hdr(16'h0001, FLAG_QR, 16'd1, 16'd0);
        question();
        ship();

        // found records, field extremes
        hdr(16'hffff, 16'hffff & ~FLAG_TC, 16'd1, 16'd1);
        question();
        answer(TYPE_CLASS_A_IN, 32'hffff_ffff, A_RDLEN, 32'hffff_ffff);
        ship();
        hdr(16'h0000, FLAG_QR, 16'd0, 16'd1);
        answer(TYPE_CLASS_A_IN, 32'd0, A_RDLEN, 32'd0);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd2, 16'd2);
        question();
        question();
        answer(CNAME_IN, $urandom, 16'd6, 32'd0);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        ship();

        // no matching answer
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        question();
        answer(TYPE_CLASS_A_IN, $urandom, 16'd16, 32'd0);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd2);
        answer(A_CHAOS, $urandom, A_RDLEN, $urandom);
        answer(AAAA_IN, $urandom, 16'd16, 32'd0);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        ship();

        // packet ends part way
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        frame.push_back(8'd3);
        frame.push_back(8'h61);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        frame.push_back(8'd0);
        junk(2);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        question();
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        frame.push_back(8'hc0);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        frame.push_back(8'hc0);
        frame.push_back(8'h0c);
        put32(TYPE_CLASS_A_IN);
        junk(1);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        cut_to(frame.size() - 2);
        ship();

        // long label, trailing bytes after a verdict, zero rdlen, 0xff pointer byte
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        frame.push_back(8'h80);
        junk(128);
        frame.push_back(8'd0);
        put32($urandom);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        junk(6);
        ship();
        hdr(16'($urandom), 16'd0, 16'd1, 16'd1);
        junk(10);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd2);
        answer(TYPE_CLASS_A_IN, $urandom, 16'd0, 32'd0);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd0, 16'd1);
        frame.push_back(8'hff);
        frame.push_back(8'h12);
        put32(TYPE_CLASS_A_IN);
        put32($urandom);
        put16(A_RDLEN);
        put32($urandom);
        ship();

        // count extremes, then a record beyond the packet limit
        hdr(16'($urandom), FLAG_QR, 16'hffff, 16'hffff);
        repeat (3) question();
        ship();
        hdr(16'($urandom), FLAG_QR, 16'd1, 16'd1);
        repeat (8) begin
            frame.push_back(8'h3f);
            junk(63);
        end
        frame.push_back(8'd0);
        put32($urandom);
        answer(TYPE_CLASS_A_IN, $urandom, A_RDLEN, $urandom);
        ship();

        while (bytes_sent < ITEM_TARGET) begin
            build_random_frame();
            ship();
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (results_owed != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dnsrp_pkg.sv
rtl/dns_response_parser.sv
rtl/dnsrp_checker.sv
verif/dnsrp_reply_checker.sv
verif/tb_top.sv
